// ===== src/brrf_pkg.sv =====
// Shared types and constants of the binary rectangle region finder.
// Holds the queue entry, region record, result kinds and scan states.
// Depends on nothing; every other file of the block uses it.
package brrf_pkg;

	// Largest image the bitmap store holds.
	localparam int MAX_ROWS = 64;
	localparam int MAX_COLS = 64;
	// Width of the row and column count registers and of in-image coordinates.
	localparam int DIM_W = 7;
	// Width of the linear load position.
	localparam int POS_W = 13;
	// Width of a column position plus a run step during the scan.
	localparam int CRD_W = DIM_W + 1;
	// Width of a full width times height product.
	localparam int AREA_W = 2 * DIM_W;
	// Widths of the coordinate and area result fields.
	localparam int OUT_POS_W = 6;
	localparam int OUT_AREA_W = 13;
	// Command queue between the loader and the scanner.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);

	typedef enum logic [1:0] {
		KIND_WIDE = 2'd0,
		KIND_AREA = 2'd1,
		KIND_TALL = 2'd2
	} kind_t;

	typedef enum logic {
		REG_ROW_COUNT = 1'b0,
		REG_COL_COUNT = 1'b1
	} reg_index_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CELL,
		S_CHK_CUR,
		S_CHK_UP,
		S_V_RD,
		S_V_CHK,
		S_H_RD,
		S_H_CHK,
		S_AREA,
		S_UPDATE,
		S_EMIT_W,
		S_EMIT_A,
		S_EMIT_T
	} scan_state_t;

	// One command from the loader: an optional pixel store, and a scan
	// request with the image size that the scan must use.
	typedef struct packed {
		logic             scan;
		logic             store;
		logic             pixel;
		logic [DIM_W-1:0] row;
		logic [DIM_W-1:0] col;
		logic [DIM_W-1:0] rows;
		logic [DIM_W-1:0] cols;
	} op_t;

	typedef struct packed {
		logic [DIM_W-1:0]  row;
		logic [DIM_W-1:0]  col;
		logic [DIM_W-1:0]  w;
		logic [DIM_W-1:0]  h;
		logic [AREA_W-1:0] area;
	} region_t;

endpackage

// ===== src/brrf_front.sv =====
// Loader front end: configuration registers, load position tracking and
// command generation for the queue. Uses brrf_pkg.
// Recomputes row and column of the load position after each register write.
module brrf_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic                         pixel,
	output logic                         busy,
	input  logic                         cfg_wr_en,
	input  logic                         cfg_index,
	input  logic [brrf_pkg::DIM_W-1:0]   cfg_wdata,
	input  logic                         fifo_full,
	output logic                         push,
	output brrf_pkg::op_t                op
);

	localparam int DW = brrf_pkg::DIM_W;
	localparam int PW = brrf_pkg::POS_W;
	localparam int CNT_W = $clog2(PW + 1);

	function automatic logic [DW-1:0] clamp_dim(input logic [DW-1:0] v, input int maxv);
		logic [DW-1:0] res;
		res = v;
		if (v == '0) begin
			res = DW'(1);
		end else if (int'(v) > maxv) begin
			res = DW'(maxv);
		end
		return res;
	endfunction

	logic [DW-1:0]    row_count_q, col_count_q;
	logic [DW-1:0]    rows, cols;
	logic [PW-1:0]    pos_q, pos_nxt;
	logic [PW-1:0]    r_q;
	logic [DW-1:0]    c_q;
	logic [DW:0]      c_inc;
	logic [2*DW-1:0]  total;
	logic             accept, complete, in_image;

	// Restoring divider state for position / columns.
	logic             div_act_q;
	logic [CNT_W-1:0] div_cnt_q;
	logic [DW-1:0]    rem_q, rem_nxt;
	logic [PW-1:0]    dq_q, dq_nxt;
	logic [DW:0]      trial;
	logic             ge;

	always_comb begin
		rows = clamp_dim(row_count_q, brrf_pkg::MAX_ROWS);
		cols = clamp_dim(col_count_q, brrf_pkg::MAX_COLS);
		total = {{DW{1'b0}}, rows} * {{DW{1'b0}}, cols};
		busy = div_act_q | fifo_full;
		accept = start & ~busy;
		pos_nxt = pos_q + PW'(1);
		complete = ({1'b0, pos_nxt} >= total);
		in_image = (r_q < {{(PW-DW){1'b0}}, rows});
		c_inc = {1'b0, c_q} + (DW+1)'(1);

		trial = {rem_q, dq_q[PW-1]};
		ge = (trial >= {1'b0, cols});
		rem_nxt = ge ? DW'(trial - {1'b0, cols}) : trial[DW-1:0];
		dq_nxt = {dq_q[PW-2:0], ge};

		push = accept;
		op.scan = complete;
		op.store = in_image;
		op.pixel = pixel;
		op.row = r_q[DW-1:0];
		op.col = c_q;
		op.rows = rows;
		op.cols = cols;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= DW'(64);
			col_count_q <= DW'(64);
			pos_q <= '0;
			r_q <= '0;
			c_q <= '0;
			div_act_q <= 1'b0;
			div_cnt_q <= '0;
			rem_q <= '0;
			dq_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (brrf_pkg::reg_index_t'(cfg_index))
				brrf_pkg::REG_ROW_COUNT: begin
					row_count_q <= cfg_wdata;
				end
				brrf_pkg::REG_COL_COUNT: begin
					col_count_q <= cfg_wdata;
				end
				default: begin
				end
			endcase
			div_act_q <= 1'b1;
			div_cnt_q <= CNT_W'(PW);
			rem_q <= '0;
			dq_q <= pos_q;
		end else if (div_act_q) begin
			rem_q <= rem_nxt;
			dq_q <= dq_nxt;
			div_cnt_q <= div_cnt_q - CNT_W'(1);
			if (div_cnt_q == CNT_W'(1)) begin
				div_act_q <= 1'b0;
				r_q <= dq_nxt;
				c_q <= rem_nxt;
			end
		end else if (accept) begin
			if (complete || pos_nxt == '0) begin
				pos_q <= '0;
				r_q <= '0;
				c_q <= '0;
			end else begin
				pos_q <= pos_nxt;
				if (c_inc == {1'b0, cols}) begin
					c_q <= '0;
					r_q <= r_q + PW'(1);
				end else begin
					c_q <= c_inc[DW-1:0];
				end
			end
		end
	end

endmodule

// ===== src/brrf_fifo.sv =====
// Short command queue between the loader and the scanner.
// Holds brrf_pkg::op_t entries; uses brrf_pkg.
module brrf_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  brrf_pkg::op_t push_op,
	input  logic          pop,
	output brrf_pkg::op_t head_op,
	output logic          full,
	output logic          empty
);

	localparam int DEPTH = brrf_pkg::QUEUE_DEPTH;
	localparam int AW = brrf_pkg::QPTR_W;
	localparam int CW = $clog2(DEPTH + 1);

	brrf_pkg::op_t entry_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign head_op = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// ===== src/brrf_scan.sv =====
// Scanner back end: owns the bitmap memory, executes queued stores and
// scans the image for regions, then emits the three best regions.
// Uses brrf_pkg.
module brrf_scan (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            q_empty,
	input  brrf_pkg::op_t                   q_op,
	output logic                            pop,
	output logic                            result_strobe,
	output logic [1:0]                      kind,
	output logic                            found,
	output logic [brrf_pkg::OUT_POS_W-1:0]  top_row,
	output logic [brrf_pkg::OUT_POS_W-1:0]  left_col,
	output logic [brrf_pkg::DIM_W-1:0]      width,
	output logic [brrf_pkg::DIM_W-1:0]      height,
	output logic [brrf_pkg::OUT_AREA_W-1:0] area,
	output logic                            last
);

	localparam int DW = brrf_pkg::DIM_W;
	localparam int XW = brrf_pkg::CRD_W;
	localparam int ARW = brrf_pkg::AREA_W;
	localparam int RW = (brrf_pkg::MAX_ROWS > 1) ? $clog2(brrf_pkg::MAX_ROWS) : 1;
	localparam int CW = (brrf_pkg::MAX_COLS > 1) ? $clog2(brrf_pkg::MAX_COLS) : 1;
	localparam int AW = RW + CW;
	localparam int DEPTH = 1 << AW;

	logic bitmap [DEPTH];
	logic rdata_q;

	brrf_pkg::scan_state_t state_q, state_d;

	logic [DW-1:0]  rows_q, cols_q;
	logic [DW-1:0]  r_q;
	logic [XW-1:0]  c_q;
	logic [XW-1:0]  k_q;
	logic [DW-1:0]  w_q, h_q;
	logic [ARW-1:0] area_q;
	logic           any_q;
	brrf_pkg::region_t best_wide_q, best_tall_q, best_area_q, cand, emit_reg;

	logic           result_strobe_q, found_q, last_q;
	brrf_pkg::kind_t kind_q;
	logic [brrf_pkg::OUT_POS_W-1:0]  top_row_q, left_col_q;
	logic [DW-1:0]  width_q, height_q;
	logic [brrf_pkg::OUT_AREA_W-1:0] area_out_q;

	logic [DW-1:0]  rd_row;
	logic [XW-1:0]  rd_col;
	logic [XW-1:0]  adv_step, nc;
	logic           row_end, last_row;
	logic           do_adv, start_v, start_h, begin_scan;
	logic           emit;
	brrf_pkg::kind_t emit_kind;
	brrf_pkg::scan_state_t adv_state;

	always_comb begin
		adv_step = (state_q == brrf_pkg::S_UPDATE) ? ({1'b0, w_q} + XW'(1)) : XW'(1);
		nc = c_q + adv_step;
		row_end = (nc >= {1'b0, cols_q});
		last_row = (({1'b0, r_q} + XW'(1)) == {1'b0, rows_q});
		adv_state = (row_end && last_row) ? brrf_pkg::S_EMIT_W : brrf_pkg::S_CELL;

		cand.row = r_q;
		cand.col = c_q[DW-1:0];
		cand.w = w_q;
		cand.h = h_q;
		cand.area = area_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= brrf_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		pop = 1'b0;
		rd_row = r_q;
		rd_col = c_q;
		do_adv = 1'b0;
		start_v = 1'b0;
		start_h = 1'b0;
		begin_scan = 1'b0;
		emit = 1'b0;
		emit_kind = brrf_pkg::KIND_WIDE;
		emit_reg = best_wide_q;
		unique case (state_q)
			brrf_pkg::S_IDLE: begin
				if (!q_empty) begin
					pop = 1'b1;
					if (q_op.scan) begin
						begin_scan = 1'b1;
						state_d = brrf_pkg::S_CELL;
					end
				end
			end
			brrf_pkg::S_CELL: begin
				state_d = brrf_pkg::S_CHK_CUR;
			end
			brrf_pkg::S_CHK_CUR: begin
				if (!rdata_q) begin
					do_adv = 1'b1;
					state_d = adv_state;
				end else if (r_q == '0) begin
					start_v = 1'b1;
					state_d = brrf_pkg::S_V_RD;
				end else begin
					rd_row = r_q - DW'(1);
					state_d = brrf_pkg::S_CHK_UP;
				end
			end
			brrf_pkg::S_CHK_UP: begin
				if (rdata_q) begin
					do_adv = 1'b1;
					state_d = adv_state;
				end else begin
					start_v = 1'b1;
					state_d = brrf_pkg::S_V_RD;
				end
			end
			brrf_pkg::S_V_RD: begin
				if (k_q == {1'b0, rows_q}) begin
					start_h = 1'b1;
					state_d = brrf_pkg::S_H_RD;
				end else begin
					rd_row = k_q[DW-1:0];
					state_d = brrf_pkg::S_V_CHK;
				end
			end
			brrf_pkg::S_V_CHK: begin
				if (rdata_q) begin
					state_d = brrf_pkg::S_V_RD;
				end else begin
					start_h = 1'b1;
					state_d = brrf_pkg::S_H_RD;
				end
			end
			brrf_pkg::S_H_RD: begin
				if (k_q == {1'b0, cols_q}) begin
					state_d = brrf_pkg::S_AREA;
				end else begin
					rd_col = k_q;
					state_d = brrf_pkg::S_H_CHK;
				end
			end
			brrf_pkg::S_H_CHK: begin
				state_d = rdata_q ? brrf_pkg::S_H_RD : brrf_pkg::S_AREA;
			end
			brrf_pkg::S_AREA: begin
				state_d = brrf_pkg::S_UPDATE;
			end
			brrf_pkg::S_UPDATE: begin
				do_adv = 1'b1;
				state_d = adv_state;
			end
			brrf_pkg::S_EMIT_W: begin
				emit = 1'b1;
				state_d = brrf_pkg::S_EMIT_A;
			end
			brrf_pkg::S_EMIT_A: begin
				emit = 1'b1;
				emit_kind = brrf_pkg::KIND_AREA;
				emit_reg = best_area_q;
				state_d = brrf_pkg::S_EMIT_T;
			end
			brrf_pkg::S_EMIT_T: begin
				emit = 1'b1;
				emit_kind = brrf_pkg::KIND_TALL;
				emit_reg = best_tall_q;
				state_d = brrf_pkg::S_IDLE;
			end
			default: begin
				state_d = brrf_pkg::S_IDLE;
			end
		endcase
	end

	// Bitmap store: one write port for loads, one registered read port for the scan.
	always_ff @(posedge clk) begin
		if (pop && q_op.store) begin
			bitmap[{RW'(q_op.row), CW'(q_op.col)}] <= q_op.pixel;
		end
		rdata_q <= bitmap[{RW'(rd_row), CW'(rd_col)}];
	end

	// Scan datapath and best-region bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= '0;
			cols_q <= '0;
			r_q <= '0;
			c_q <= '0;
			k_q <= '0;
			w_q <= '0;
			h_q <= '0;
			area_q <= '0;
			any_q <= 1'b0;
			best_wide_q <= '0;
			best_tall_q <= '0;
			best_area_q <= '0;
		end else begin
			if (begin_scan) begin
				rows_q <= q_op.rows;
				cols_q <= q_op.cols;
				r_q <= '0;
				c_q <= '0;
				any_q <= 1'b0;
				best_wide_q <= '0;
				best_tall_q <= '0;
				best_area_q <= '0;
			end
			if (start_v) begin
				h_q <= DW'(1);
				k_q <= {1'b0, r_q} + XW'(1);
			end
			if (start_h) begin
				w_q <= DW'(1);
				k_q <= c_q + XW'(1);
			end
			if (state_q == brrf_pkg::S_V_CHK && rdata_q) begin
				h_q <= h_q + DW'(1);
				k_q <= k_q + XW'(1);
			end
			if (state_q == brrf_pkg::S_H_CHK && rdata_q) begin
				w_q <= w_q + DW'(1);
				k_q <= k_q + XW'(1);
			end
			if (state_q == brrf_pkg::S_AREA) begin
				area_q <= {{DW{1'b0}}, w_q} * {{DW{1'b0}}, h_q};
			end
			if (state_q == brrf_pkg::S_UPDATE) begin
				any_q <= 1'b1;
				// Strictly greater only, so the earliest region keeps a tie.
				if (w_q > best_wide_q.w) begin
					best_wide_q <= cand;
				end
				if (h_q > best_tall_q.h) begin
					best_tall_q <= cand;
				end
				if (area_q > best_area_q.area) begin
					best_area_q <= cand;
				end
			end
			if (do_adv) begin
				if (row_end) begin
					r_q <= r_q + DW'(1);
					c_q <= '0;
				end else begin
					c_q <= nc;
				end
			end
		end
	end

	// Result register: one beat per cycle while emitting.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_strobe_q <= 1'b0;
			kind_q <= brrf_pkg::KIND_WIDE;
			found_q <= 1'b0;
			last_q <= 1'b0;
			top_row_q <= '0;
			left_col_q <= '0;
			width_q <= '0;
			height_q <= '0;
			area_out_q <= '0;
		end else begin
			result_strobe_q <= emit;
			if (emit) begin
				kind_q <= emit_kind;
				found_q <= any_q;
				last_q <= (emit_kind == brrf_pkg::KIND_TALL);
				top_row_q <= brrf_pkg::OUT_POS_W'(emit_reg.row);
				left_col_q <= brrf_pkg::OUT_POS_W'(emit_reg.col);
				width_q <= emit_reg.w;
				height_q <= emit_reg.h;
				area_out_q <= brrf_pkg::OUT_AREA_W'(emit_reg.area);
			end
		end
	end

	assign result_strobe = result_strobe_q;
	assign kind = kind_q;
	assign found = found_q;
	assign top_row = top_row_q;
	assign left_col = left_col_q;
	assign width = width_q;
	assign height = height_q;
	assign area = area_out_q;
	assign last = last_q;

endmodule

// ===== src/binary_rectangle_region_finder_core.sv =====
// Top level of the binary rectangle region finder.
// Instantiates brrf_front, brrf_fifo and brrf_scan; uses brrf_pkg.
//
// The block takes a binary image one pixel per beat in row-major order
// (start high while busy is low) and stores it in an internal bitmap. The
// pixel that completes row_count times col_count pixels starts a scan for
// black rectangles; when the scan ends, three result beats follow on
// consecutive cycles, each marked by result_strobe for one cycle: the widest
// region, the region of largest area and the tallest region, the last of them
// flagged by last. The receiver cannot stall results, so it must take every
// strobed beat. Loading runs at one pixel per cycle while busy is low. The
// pixel that completes an image is queued with the scan, and up to two
// further pixels of the next image are taken before busy rises; busy then
// stays high for the scan. The scan walks the bitmap through its single read
// port: it reads each cell visited, and for a black cell not in row 0 also
// the cell above it; a black cell with a white cell above it (or in row 0)
// starts a region, whose vertical run down its column and horizontal run
// along its row are read cell by cell, after which its area is formed and
// the best regions are updated. A configuration write holds busy while the
// row and column of the load position are recomputed by a bit-serial
// divider. Configuration must be written only while no image scan is
// running; the block itself does not enforce it.
module binary_rectangle_region_finder_core (
	input  logic                            clk,
	input  logic                            arst_n,
	// Pixel input
	input  logic                            start,
	input  logic                            pixel,
	output logic                            busy,
	// Configuration write port
	input  logic                            cfg_wr_en,
	input  logic                            cfg_index,
	input  logic [brrf_pkg::DIM_W-1:0]      cfg_wdata,
	// Results
	output logic                            result_strobe,
	output logic [1:0]                      kind,
	output logic                            found,
	output logic [brrf_pkg::OUT_POS_W-1:0]  top_row,
	output logic [brrf_pkg::OUT_POS_W-1:0]  left_col,
	output logic [brrf_pkg::DIM_W-1:0]      width,
	output logic [brrf_pkg::DIM_W-1:0]      height,
	output logic [brrf_pkg::OUT_AREA_W-1:0] area,
	output logic                            last
);

	// Commands from the loader to the scanner. Each carries a store of the
	// incoming pixel (when it falls inside the image) and, on the final
	// pixel, a scan request together with the image size in force.
	brrf_pkg::op_t push_op, head_op;
	logic          push, pop, fifo_full, fifo_empty;

	// The front end owns the configuration and the load position.
	brrf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.pixel     (pixel),
		.busy      (busy),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.fifo_full (fifo_full),
		.push      (push),
		.op        (push_op)
	);

	// The queue lets loading run ahead while the scanner is busy, and keeps
	// the next image's pixels from overwriting the bitmap before the scan.
	brrf_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.pop     (pop),
		.head_op (head_op),
		.full    (fifo_full),
		.empty   (fifo_empty)
	);

	// The back end writes the bitmap, scans it and emits the results.
	brrf_scan u_scan (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (fifo_empty),
		.q_op          (head_op),
		.pop           (pop),
		.result_strobe (result_strobe),
		.kind          (kind),
		.found         (found),
		.top_row       (top_row),
		.left_col      (left_col),
		.width         (width),
		.height        (height),
		.area          (area),
		.last          (last)
	);

endmodule

// ===== src/brrf_checker.sv =====
// Port-level checker for the binary rectangle region finder, bound to the top.
// Uses brrf_pkg for the result kind codes.
module brrf_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            start,
	input logic                            pixel,
	input logic                            busy,
	input logic                            cfg_wr_en,
	input logic                            cfg_index,
	input logic [brrf_pkg::DIM_W-1:0]      cfg_wdata,
	input logic                            result_strobe,
	input logic [1:0]                      kind,
	input logic                            found,
	input logic [brrf_pkg::OUT_POS_W-1:0]  top_row,
	input logic [brrf_pkg::OUT_POS_W-1:0]  left_col,
	input logic [brrf_pkg::DIM_W-1:0]      width,
	input logic [brrf_pkg::DIM_W-1:0]      height,
	input logic [brrf_pkg::OUT_AREA_W-1:0] area,
	input logic                            last
);

	logic [brrf_pkg::AREA_W-1:0] prod;

	assign prod = {{brrf_pkg::DIM_W{1'b0}}, width} * {{brrf_pkg::DIM_W{1'b0}}, height};

	// The last flag marks the tallest-region beat and nothing else.
	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> (last == (kind == brrf_pkg::KIND_TALL)))
		else $error("last flag does not match the tallest-region beat");

	// The three results of an image come back to back in a fixed order.
	a_wide_then_area: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && kind == brrf_pkg::KIND_WIDE
		|=> result_strobe && kind == brrf_pkg::KIND_AREA)
		else $error("widest-region beat not followed by largest-area beat");

	a_area_then_tall: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && kind == brrf_pkg::KIND_AREA
		|=> result_strobe && kind == brrf_pkg::KIND_TALL)
		else $error("largest-area beat not followed by tallest-region beat");

	// An image with no region reports an all-zero region.
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !found |-> width == '0 && height == '0 && area == '0
		&& top_row == '0 && left_col == '0)
		else $error("empty image reported a nonzero region");

	// The reported area is the product of the reported width and height.
	a_area_product: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> area == prod[brrf_pkg::OUT_AREA_W-1:0])
		else $error("area does not equal width times height");

endmodule

bind binary_rectangle_region_finder_core brrf_checker u_brrf_checker (.*);
